// ===== rtl/bcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier package
// Shared widths, reset values, register indexes, event codes and types.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int NOW_W       = 32;
    localparam int TIME_BITS_D = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 24'd1000;
    localparam logic [CFG_W-1:0] SHORT_RST    = 24'd300000;
    localparam logic [CFG_W-1:0] LONG_RST     = 24'd800000;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd2;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SINGLE = 2'd1;
    localparam logic [1:0] EV_DOUBLE = 2'd2;
    localparam logic [1:0] EV_LONG   = 2'd3;

    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] stable_time_us;
        logic [CFG_W-1:0] short_window_us;
        logic [CFG_W-1:0] long_press_us;
    } cfg_t;

endpackage

// ===== rtl/bcc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier configuration registers
// Holds the debounce, short window and long press times.
// ----------------------------------------------------------------------------
module bcc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]      cfg_data,
    output bcc_pkg::cfg_t                  cfg
);

    bcc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stable_time_us  <= bcc_pkg::DEBOUNCE_RST;
            cfg_reg.short_window_us <= bcc_pkg::SHORT_RST;
            cfg_reg.long_press_us   <= bcc_pkg::LONG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bcc_pkg::REG_DEBOUNCE: cfg_reg.stable_time_us  <= cfg_data;
                bcc_pkg::REG_SHORT:    cfg_reg.short_window_us <= cfg_data;
                bcc_pkg::REG_LONG:     cfg_reg.long_press_us   <= cfg_data;
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/bcc_debounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier debouncer
// Accepts a new raw level once it has been stable for the debounce time.
// ----------------------------------------------------------------------------
module bcc_debounce #(
    parameter int TIME_BITS = bcc_pkg::TIME_BITS_D
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic                 raw,
    input  logic [TIME_BITS-1:0] now,
    input  logic [bcc_pkg::CFG_W-1:0] stable_time_us,
    output logic                 lvl
);

    localparam int CMP_W = (TIME_BITS > bcc_pkg::CFG_W) ? TIME_BITS : bcc_pkg::CFG_W;

    logic                 last_raw_reg;
    logic                 last_raw_next;
    logic [TIME_BITS-1:0] change_time_reg;
    logic [TIME_BITS-1:0] change_time_next;
    logic                 stable_level_reg;
    logic                 stable_level_next;
    logic [TIME_BITS-1:0] elapsed;

    always_comb
    begin
        last_raw_next    = last_raw_reg;
        change_time_next = change_time_reg;
        if (raw != last_raw_reg)
        begin
            last_raw_next    = raw;
            change_time_next = now;
        end
        elapsed = now - change_time_next;
        if (CMP_W'(elapsed) >= CMP_W'(stable_time_us))
            stable_level_next = last_raw_next;
        else
            stable_level_next = stable_level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg     <= bcc_pkg::LVL_RELEASED;
            change_time_reg  <= '0;
            stable_level_reg <= bcc_pkg::LVL_RELEASED;
        end
        else if (step_en)
        begin
            last_raw_reg     <= last_raw_next;
            change_time_reg  <= change_time_next;
            stable_level_reg <= stable_level_next;
        end
    end

    assign lvl = stable_level_next;

endmodule

// ===== rtl/bcc_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier state machine
// Counts clicks on the clean level and reports single, double and long press.
// ----------------------------------------------------------------------------
module bcc_classifier #(
    parameter int TIME_BITS = bcc_pkg::TIME_BITS_D
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic                 lvl,
    input  logic [TIME_BITS-1:0] now,
    input  bcc_pkg::cfg_t        cfg,
    output logic [1:0]           ev
);

    localparam int CMP_W = (TIME_BITS > bcc_pkg::CFG_W) ? TIME_BITS : bcc_pkg::CFG_W;

    typedef enum logic [2:0] {
        ST_INIT          = 3'd0,
        ST_PRESSED       = 3'd1,
        ST_RELEASED      = 3'd2,
        ST_COUNTING      = 3'd3,
        ST_HELD          = 3'd4,
        ST_HELD_RELEASED = 3'd5
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [TIME_BITS-1:0] press_start_reg;
    logic [TIME_BITS-1:0] press_start_next;
    logic [1:0]           clicks_reg;
    logic [1:0]           clicks_next;
    logic [TIME_BITS-1:0] dur;
    logic                 long_hit;
    logic                 window_hit;

    always_comb
    begin
        state_next       = state_reg;
        press_start_next = press_start_reg;
        clicks_next      = clicks_reg;
        ev               = bcc_pkg::EV_NONE;
        dur              = now - press_start_reg;
        long_hit         = CMP_W'(dur) > CMP_W'(cfg.long_press_us);
        window_hit       = CMP_W'(dur) >= CMP_W'(cfg.short_window_us);

        case (state_reg)
            ST_PRESSED:
            begin
                if (lvl == bcc_pkg::LVL_RELEASED)
                begin
                    state_next       = ST_RELEASED;
                    press_start_next = now;
                end
                else if (long_hit)
                begin
                    ev         = bcc_pkg::EV_LONG;
                    state_next = ST_HELD;
                end
            end
            ST_RELEASED:
            begin
                if (clicks_reg != 2'd3)
                    clicks_next = clicks_reg + 2'd1;
                state_next = ST_COUNTING;
            end
            ST_COUNTING:
            begin
                if (lvl == bcc_pkg::LVL_PRESSED)
                begin
                    state_next       = ST_PRESSED;
                    press_start_next = now;
                end
                else if (window_hit || clicks_reg == 2'd2)
                begin
                    if (clicks_reg == 2'd1)
                        ev = bcc_pkg::EV_SINGLE;
                    else if (clicks_reg == 2'd2)
                        ev = bcc_pkg::EV_DOUBLE;
                    state_next       = ST_INIT;
                    clicks_next      = 2'd0;
                    press_start_next = '0;
                end
            end
            ST_HELD:
            begin
                if (lvl == bcc_pkg::LVL_RELEASED)
                begin
                    state_next       = ST_HELD_RELEASED;
                    press_start_next = now;
                end
            end
            ST_HELD_RELEASED:
            begin
                state_next       = ST_INIT;
                clicks_next      = 2'd0;
                press_start_next = '0;
            end
            default:
            begin
                if (lvl == bcc_pkg::LVL_PRESSED)
                begin
                    state_next       = ST_PRESSED;
                    press_start_next = now;
                    clicks_next      = 2'd0;
                end
                else
                begin
                    state_next = ST_INIT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            press_start_reg <= '0;
            clicks_reg      <= 2'd0;
        end
        else if (step_en)
        begin
            state_reg       <= state_next;
            press_start_reg <= press_start_next;
            clicks_reg      <= clicks_next;
        end
    end

endmodule

// ===== rtl/button_click_classifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier top level
// Debounces a sampled button level and classifies single, double and long
// presses, one event per sample.
// ----------------------------------------------------------------------------
// Each input beat carries one raw level sample and its microsecond timestamp.
// Each accepted beat yields exactly one output beat with the event code and
// the debounced level after that sample, in order.
// A beat accepted at a clock edge is captured in the input register, runs
// through the debouncer and the state machine while it is held there, and is
// loaded into the output register at the first edge at which the output
// register can advance, that is, when it is empty or not stalled.
// The input and output registers let a new beat enter every cycle while the
// receiver does not stall, so the sustained rate is one sample per clock.
// When the receiver stalls, the output beat holds; the input register still
// takes one more beat, after which in_stall rises until the output drains.
// Configuration writes take effect at the next edge and are meant for idle
// periods only.
// Reset clears both registers' valid flags, returns the state machine to its
// initial state with the levels released and loads the default times.
// ----------------------------------------------------------------------------
module button_click_classifier_top #(
    parameter int TIME_BITS = bcc_pkg::TIME_BITS_D
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          raw_level,
    input  logic [bcc_pkg::NOW_W-1:0]     now_us,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    event_code,
    output logic                          clean_level,
    input  logic                          cfg_we,
    input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]     cfg_data
);

    bcc_pkg::cfg_t        cfg;
    logic                 s1_valid_reg;
    logic                 s1_raw_reg;
    logic [TIME_BITS-1:0] s1_now_reg;
    logic                 out_valid_reg;
    logic [1:0]           event_code_reg;
    logic                 clean_level_reg;
    logic                 advance;
    logic                 in_take;
    logic                 step_en;
    logic                 lvl;
    logic [1:0]           ev;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign step_en  = s1_valid_reg && advance;

    bcc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcc_debounce #(
        .TIME_BITS (TIME_BITS)
    ) u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_en),
        .raw            (s1_raw_reg),
        .now            (s1_now_reg),
        .stable_time_us (cfg.stable_time_us),
        .lvl            (lvl)
    );

    bcc_classifier #(
        .TIME_BITS (TIME_BITS)
    ) u_classifier (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .lvl     (lvl),
        .now     (s1_now_reg),
        .cfg     (cfg),
        .ev      (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_raw_reg <= raw_level;
            s1_now_reg <= TIME_BITS'(now_us);
        end
        if (step_en)
        begin
            event_code_reg  <= ev;
            clean_level_reg <= lvl;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_code  = event_code_reg;
    assign clean_level = clean_level_reg;

endmodule

// ===== rtl/bcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier port checker
// Watches the top level's ports for handshake and event consistency.
// ----------------------------------------------------------------------------
module bcc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] event_code,
    input logic       clean_level
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Output beat dropped while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(event_code) && $stable(clean_level))
        else $error("Output payload changed while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("Input stalled without a stalled output beat.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == bcc_pkg::EV_LONG |-> clean_level == bcc_pkg::LVL_PRESSED)
        else $error("Long press reported with the button released.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == bcc_pkg::EV_SINGLE || event_code == bcc_pkg::EV_DOUBLE)
        |-> clean_level == bcc_pkg::LVL_RELEASED)
        else $error("Click reported with the button pressed.");

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_code  (event_code),
    .clean_level (clean_level)
);

// ===== test/bcc_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier event checker
// Watches the sample, result and register ports of the classifier, keeps its
// own debouncer and click state machine, predicts the event and clean level
// of every accepted sample and compares them in order with the result beats.
// ----------------------------------------------------------------------------
module bcc_event_checker
    import bcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 raw_level,
    input  logic [NOW_W-1:0]     now_us,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [1:0]           event_code,
    input  logic                 clean_level,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending_count
);

    typedef enum logic [2:0] {
        S_INIT          = 3'd0,
        S_PRESSED       = 3'd1,
        S_RELEASED      = 3'd2,
        S_COUNTING      = 3'd3,
        S_HELD          = 3'd4,
        S_HELD_RELEASED = 3'd5
    } click_phase_t;

    typedef struct packed {
        logic [1:0] ev;
        logic       lvl;
    } click_result_t;

    cfg_t             timing;
    click_phase_t     phase;
    logic [NOW_W-1:0] hold_start;
    logic [NOW_W-1:0] edge_time;
    logic [1:0]       taps;
    logic             settled;
    logic             seen_raw;
    click_result_t    pending_events[$];

    task automatic classify_sample(input logic raw, input logic [NOW_W-1:0] stamp,
                                   output click_result_t res);
        logic [NOW_W-1:0] stable_for;
        logic [NOW_W-1:0] held;
        res.ev = EV_NONE;
        if (raw != seen_raw)
        begin
            edge_time = stamp;
            seen_raw  = raw;
        end
        stable_for = stamp - edge_time;
        if (stable_for >= NOW_W'(timing.stable_time_us))
            settled = seen_raw;
        res.lvl = settled;
        held = stamp - hold_start;
        case (phase)
            S_PRESSED:
            begin
                if (settled == LVL_RELEASED)
                begin
                    phase      = S_RELEASED;
                    hold_start = stamp;
                end
                else if (held > NOW_W'(timing.long_press_us))
                begin
                    res.ev = EV_LONG;
                    phase  = S_HELD;
                end
            end
            S_RELEASED:
            begin
                if (taps != 2'd3)
                    taps = taps + 2'd1;
                phase = S_COUNTING;
            end
            S_COUNTING:
            begin
                if (settled == LVL_PRESSED)
                begin
                    phase      = S_PRESSED;
                    hold_start = stamp;
                end
                else if (held >= NOW_W'(timing.short_window_us) || taps == 2'd2)
                begin
                    if (taps == 2'd1)
                        res.ev = EV_SINGLE;
                    else if (taps == 2'd2)
                        res.ev = EV_DOUBLE;
                    phase      = S_INIT;
                    taps       = 2'd0;
                    hold_start = '0;
                end
            end
            S_HELD:
            begin
                if (settled == LVL_RELEASED)
                begin
                    phase      = S_HELD_RELEASED;
                    hold_start = stamp;
                end
            end
            S_HELD_RELEASED:
            begin
                phase      = S_INIT;
                taps       = 2'd0;
                hold_start = '0;
            end
            default:
            begin
                if (settled == LVL_PRESSED)
                begin
                    phase      = S_PRESSED;
                    hold_start = stamp;
                    taps       = 2'd0;
                end
                else
                begin
                    phase = S_INIT;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        click_result_t want;
        click_result_t got;
        if (!rst_n)
        begin
            timing     = '{DEBOUNCE_RST, SHORT_RST, LONG_RST};
            phase      = S_INIT;
            hold_start = '0;
            edge_time  = '0;
            taps       = 2'd0;
            settled    = LVL_RELEASED;
            seen_raw   = LVL_RELEASED;
            pending_events.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{event_code, clean_level};
                if (pending_events.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat with none expected: event %0d level %0d",
                             $time, event_code, clean_level);
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (got.ev !== want.ev || got.lvl !== want.lvl)
                    begin
                        fail_count++;
                        $display("%0t: expected event %0d level %0d, got event %0d level %0d",
                                 $time, want.ev, want.lvl, got.ev, got.lvl);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEBOUNCE: timing.stable_time_us  = cfg_data;
                    REG_SHORT:    timing.short_window_us = cfg_data;
                    REG_LONG:     timing.long_press_us   = cfg_data;
                    default:      ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                classify_sample(raw_level, now_us, want);
                pending_events.push_back(want);
            end
        end
        pending_count = pending_events.size();
    end

endmodule

// ===== test/tb_button_click_classifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier testbench
// Drives timestamped button samples into the classifier: a directed run of
// long, single and double presses with the default times, then random press
// gestures with contact bounce, line noise and timestamp jumps under several
// timing settings and idle patterns. The event checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_button_click_classifier_top;
    import bcc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 raw_level;
    logic [NOW_W-1:0]     now_us;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           event_code;
    logic                 clean_level;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending_count;
    int                   send_pct;
    int                   recv_pct = 0;
    int                   samples_sent;
    int unsigned          clock_us;
    int unsigned          step_span;
    logic [CFG_W-1:0]     cur_debounce;
    logic [CFG_W-1:0]     cur_short;
    logic [CFG_W-1:0]     cur_long;

    button_click_classifier_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .raw_level   (raw_level),
        .now_us      (now_us),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_code  (event_code),
        .clean_level (clean_level),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    bcc_event_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .raw_level     (raw_level),
        .now_us        (now_us),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_code    (event_code),
        .clean_level   (clean_level),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_pct);
    end

    initial
    begin
        #20_000_000;
        $display("FAIL button_click_classifier_top");
        $finish;
    end

    task automatic send_sample(input logic raw, input logic [NOW_W-1:0] stamp);
        while ($urandom_range(0, 99) < send_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        raw_level <= raw;
        now_us    <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        samples_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_timing(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] short_win,
                               input logic [CFG_W-1:0] long_hold);
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_SHORT, short_win);
        write_reg(REG_LONG, long_hold);
        write_reg(REG_UNUSED, CFG_W'($urandom()));
        cur_debounce = debounce;
        cur_short    = short_win;
        cur_long     = long_hold;
        step_span    = (32'(debounce) + 32'(short_win) + 32'(long_hold)) / 12 + 1;
    endtask

    task automatic bounce_to(input logic level);
        int n;
        n = $urandom_range(0, 3);
        repeat (n) begin
            clock_us += $urandom_range(0, step_span / 2);
            send_sample($urandom_range(0, 1) == 1, clock_us);
        end
        clock_us += $urandom_range(1, step_span);
        send_sample(level, clock_us);
    endtask

    task automatic hold_level(input logic level, input int unsigned span_us);
        int unsigned start;
        start = clock_us;
        while (clock_us - start < span_us) begin
            clock_us += $urandom_range(1, step_span);
            send_sample(level, clock_us);
        end
    endtask

    task automatic click_gesture();
        int unsigned hold_us;
        int unsigned gap_us;
        if ($urandom_range(0, 1) == 1)
            hold_us = $urandom_range(0, cur_long);
        else
            hold_us = cur_long + $urandom_range(1, cur_long + step_span);
        if ($urandom_range(0, 1) == 1)
            gap_us = $urandom_range(0, cur_short);
        else
            gap_us = cur_short + $urandom_range(1, 4 * step_span);
        bounce_to(LVL_PRESSED);
        hold_level(LVL_PRESSED, hold_us);
        bounce_to(LVL_RELEASED);
        hold_level(LVL_RELEASED, gap_us);
    endtask

    task automatic line_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) begin
            if ($urandom_range(0, 1) == 1)
                clock_us = $urandom();
            else
                clock_us += $urandom_range(0, step_span);
            send_sample($urandom_range(0, 1) == 1, clock_us);
        end
    endtask

    initial
    begin
        int mode;
        int sub;
        int target;
        in_valid     = 1'b0;
        raw_level    = LVL_RELEASED;
        now_us       = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_DEBOUNCE;
        cfg_data     = '0;
        rst_n        = 1'b0;
        send_pct     = 0;
        samples_sent = 0;
        clock_us     = 0;
        cur_debounce = DEBOUNCE_RST;
        cur_short    = SHORT_RST;
        cur_long     = LONG_RST;
        step_span    = 1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Long press across a timestamp wrap, then a single and a double click.
        send_sample(LVL_RELEASED, 32'd0);
        send_sample(LVL_PRESSED, 32'hFFFF_FFFF);
        send_sample(LVL_PRESSED, 32'd500);
        send_sample(LVL_PRESSED, 32'd1000);
        send_sample(LVL_PRESSED, 32'd900000);
        send_sample(LVL_RELEASED, 32'd900100);
        send_sample(LVL_RELEASED, 32'd901100);
        send_sample(LVL_RELEASED, 32'd901200);
        send_sample(LVL_PRESSED, 32'd1000000);
        send_sample(LVL_PRESSED, 32'd1001000);
        send_sample(LVL_RELEASED, 32'd1100000);
        send_sample(LVL_RELEASED, 32'd1101000);
        send_sample(LVL_RELEASED, 32'd1101001);
        send_sample(LVL_RELEASED, 32'd1401000);
        send_sample(LVL_PRESSED, 32'd1500000);
        send_sample(LVL_PRESSED, 32'd1501000);
        send_sample(LVL_RELEASED, 32'd1600000);
        send_sample(LVL_RELEASED, 32'd1601000);
        send_sample(LVL_RELEASED, 32'd1601001);
        send_sample(LVL_PRESSED, 32'd1650000);
        send_sample(LVL_PRESSED, 32'd1651000);
        send_sample(LVL_RELEASED, 32'd1700000);
        send_sample(LVL_RELEASED, 32'd1701000);
        send_sample(LVL_RELEASED, 32'd1701001);
        send_sample(LVL_RELEASED, 32'd1701002);
        settle();

        for (mode = 0; mode < 3; mode++) begin
            send_pct = (mode == 0) ? 7 : (mode == 1) ? 81 : 0;
            recv_pct = (mode == 0) ? 81 : (mode == 1) ? 7 : 0;
            for (sub = 0; sub < 3; sub++) begin
                if (mode * 3 + sub == 1)
                    load_timing('0, '0, '0);
                else if (mode * 3 + sub == 5)
                    load_timing('1, '1, '1);
                else
                    load_timing(CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(20, 200)),
                                CFG_W'($urandom_range(50, 400)));
                clock_us = $urandom();
                target   = samples_sent + 215;
                while (samples_sent < target) begin
                    if ($urandom_range(0, 9) == 0)
                        line_noise();
                    else
                        click_gesture();
                end
                settle();
            end
        end

        if (fail_count == 0)
            $display("PASS button_click_classifier_top");
        else
            $display("FAIL button_click_classifier_top");
        $finish;
    end

endmodule
